// ===== hw/rtl/avcnib_pkg.sv =====
// ----------------------------------------------------------------------------
// AVC NAL index builder package
// Shared types and constants for the parser front end, job queue and emitter.
// ----------------------------------------------------------------------------
package avcnib_pkg;

  // Result kinds on the output side.
  localparam logic KindEntry   = 1'b0;
  localparam logic KindSummary = 1'b1;

  // One job per accepted byte that causes results: an optional index entry
  // followed by an optional end-of-sample summary.
  typedef struct packed {
    logic        has_entry;
    logic [31:0] entry_offset;
    logic [31:0] entry_size;
    logic        has_summary;
    logic [31:0] sum_count;
    logic [31:0] sum_frame_len;
  } job_t;

endpackage

// ===== hw/rtl/avc_nal_index_builder_top.sv =====
// Path: a byte that causes results writes its job into the job queue when it is accepted;
// the emitter then loads that job into its holding register and shows the first result.
// Throughput: one byte per cycle while the job queue is not full; one result per cycle
// leaves while pop is held; two results from one byte are absorbed by the job queue.
// Reset: asynchronous, active low; the parser waits for the first byte of a sample and
// the job queue and output register are empty.
// ----------------------------------------------------------------------------
// AVC NAL index builder top level
// Parser front end, job queue and result emitter for length-prefixed AVC samples.
// ----------------------------------------------------------------------------
module avc_nal_index_builder_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic [31:0] frame_len_i,
  input  logic [31:0] dec_info_size_i,
  input  logic        first_frame_i,
  output logic        empty,
  input  logic        pop,
  output logic        kind_o,
  output logic [31:0] nal_offset_o,
  output logic [31:0] nal_size_o,
  output logic [31:0] nal_count_o,
  output logic [31:0] new_frame_len_o,
  output logic        last_o
);

  avcnib_pkg::job_t new_job;
  avcnib_pkg::job_t head_job;
  logic             job_push;
  logic             job_pop;
  logic             q_full;
  logic             q_empty;

  assign full = q_full;

  // Byte parser.
  avcnib_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (push),
    .queue_full_i    (q_full),
    .data_byte_i     (data_byte_i),
    .frame_len_i     (frame_len_i),
    .dec_info_size_i (dec_info_size_i),
    .first_frame_i   (first_frame_i),
    .job_push_o      (job_push),
    .job_o           (new_job)
  );

  // Job queue between parser and emitter.
  avcnib_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (job_push),
    .push_job_i (new_job),
    .full_o     (q_full),
    .pop_i      (job_pop),
    .head_job_o (head_job),
    .empty_o    (q_empty)
  );

  // Result emitter.
  avcnib_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_job_i      (head_job),
    .queue_empty_i   (q_empty),
    .queue_pop_o     (job_pop),
    .pop_i           (pop),
    .empty_o         (empty),
    .kind_o          (kind_o),
    .nal_offset_o    (nal_offset_o),
    .nal_size_o      (nal_size_o),
    .nal_count_o     (nal_count_o),
    .new_frame_len_o (new_frame_len_o),
    .last_o          (last_o)
  );

endmodule

// ===== hw/rtl/avcnib_front.sv =====
// ----------------------------------------------------------------------------
// AVC NAL index builder front end
// Walks the sample one byte per beat and turns each byte that causes results into a job.
// ----------------------------------------------------------------------------
module avcnib_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic                queue_full_i,
  input  logic [7:0]          data_byte_i,
  input  logic [31:0]         frame_len_i,
  input  logic [31:0]         dec_info_size_i,
  input  logic                first_frame_i,
  output logic                job_push_o,
  output avcnib_pkg::job_t    job_o
);

  // Parser phases.
  localparam logic [2:0] PhIdle     = 3'd0;
  localparam logic [2:0] PhHeader   = 3'd1;
  localparam logic [2:0] PhSps      = 3'd2;
  localparam logic [2:0] PhPpsCount = 3'd3;
  localparam logic [2:0] PhPps      = 3'd4;
  localparam logic [2:0] PhRecDone  = 3'd5;
  localparam logic [2:0] PhSlice    = 3'd6;
  localparam logic [2:0] PhTail     = 3'd7;

  logic [2:0]  phase_q, phase_d;
  logic [31:0] byte_pos_q, byte_pos_d;
  logic [1:0]  fbi_q, fbi_d;
  logic [31:0] acc_q, acc_d;
  logic [7:0]  sets_q, sets_d;
  logic [31:0] skip_q, skip_d;
  logic [31:0] total_q, total_d;
  logic [31:0] npp_q, npp_d;
  logic [31:0] flen_q, flen_d;
  logic [31:0] sstart_q, sstart_d;

  logic        accept;
  assign accept = push_i && !queue_full_i;

  // Next-state and job computation for one byte.
  always_comb begin
    logic [32:0] pay;
    logic [32:0] nxt;
    logic [31:0] sz;
    phase_d    = phase_q;
    byte_pos_d = byte_pos_q;
    fbi_d      = fbi_q;
    acc_d      = acc_q;
    sets_d     = sets_q;
    skip_d     = skip_q;
    total_d    = total_q;
    npp_d      = npp_q;
    flen_d     = flen_q;
    sstart_d   = sstart_q;
    job_o      = '0;
    pay        = {1'b0, byte_pos_q} + 33'd1;
    nxt        = '0;
    sz         = '0;

    // The first byte of a sample latches its description.
    if (phase_q == PhIdle) begin
      flen_d     = (frame_len_i == 32'd0) ? 32'd1 : frame_len_i;
      sstart_d   = first_frame_i ? dec_info_size_i : 32'd0;
      byte_pos_d = '0;
      total_d    = '0;
      fbi_d      = '0;
      acc_d      = '0;
      sets_d     = '0;
      skip_d     = '0;
      npp_d      = sstart_d;
      phase_d    = (first_frame_i && sstart_d != 32'd0) ? PhHeader : PhSlice;
    end else if (phase_q >= PhHeader && phase_q <= PhRecDone && byte_pos_q == sstart_q) begin
      // The record walk ends at the slice start.
      phase_d = PhSlice;
      npp_d   = byte_pos_q;
      fbi_d   = '0;
      acc_d   = '0;
    end

    pay = {1'b0, byte_pos_d} + 33'd1;

    unique case (phase_d)
      PhHeader: begin
        if (byte_pos_d == 32'd5) begin
          sets_d  = {3'b000, data_byte_i[4:0]};
          fbi_d   = '0;
          skip_d  = '0;
          phase_d = (data_byte_i[4:0] != 5'd0) ? PhSps : PhPpsCount;
        end
      end
      PhSps, PhPps: begin
        if (skip_d != 32'd0) begin
          skip_d = skip_d - 32'd1;
        end else if (fbi_d == 2'd0) begin
          acc_d = {24'd0, data_byte_i};
          fbi_d = 2'd1;
        end else begin
          sz                 = {16'd0, acc_d[7:0], data_byte_i};
          job_o.has_entry    = 1'b1;
          job_o.entry_offset = pay[31:0];
          job_o.entry_size   = sz;
          total_d            = total_d + 32'd1;
          skip_d             = sz;
          sets_d             = sets_d - 8'd1;
          fbi_d              = '0;
        end
        if (skip_d == 32'd0 && fbi_d == 2'd0 && sets_d == 8'd0) begin
          phase_d = (phase_d == PhSps) ? PhPpsCount : PhRecDone;
        end
      end
      PhPpsCount: begin
        sets_d  = data_byte_i;
        fbi_d   = '0;
        skip_d  = '0;
        phase_d = (data_byte_i != 8'd0) ? PhPps : PhRecDone;
      end
      PhSlice: begin
        if (fbi_d != 2'd0 || byte_pos_d == npp_d) begin
          acc_d = (fbi_d == 2'd0) ? {24'd0, data_byte_i} : {acc_d[23:0], data_byte_i};
          if (fbi_d == 2'd3) begin
            nxt = pay + {1'b0, acc_d};
            if (pay < {1'b0, flen_d}) begin
              job_o.has_entry    = 1'b1;
              job_o.entry_offset = pay[31:0];
              job_o.entry_size   = acc_d;
              total_d            = total_d + 32'd1;
            end
            fbi_d = '0;
            if (nxt[32]) begin
              phase_d = PhTail;
            end else begin
              npp_d = nxt[31:0];
            end
          end else begin
            fbi_d = fbi_d + 2'd1;
          end
        end
      end
      default: begin
      end
    endcase

    // The last byte of the sample closes it with a summary.
    if (pay >= {1'b0, flen_d}) begin
      job_o.has_summary   = 1'b1;
      job_o.sum_count     = total_d;
      job_o.sum_frame_len = flen_d;
      phase_d             = PhIdle;
      byte_pos_d          = '0;
    end else begin
      byte_pos_d = pay[31:0];
    end
  end

  assign job_push_o = accept && (job_o.has_entry || job_o.has_summary);

  // Parser state advances on every accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      byte_pos_q <= '0;
      fbi_q      <= '0;
      acc_q      <= '0;
      sets_q     <= '0;
      skip_q     <= '0;
      total_q    <= '0;
      npp_q      <= '0;
      flen_q     <= '0;
      sstart_q   <= '0;
    end else if (accept) begin
      phase_q    <= phase_d;
      byte_pos_q <= byte_pos_d;
      fbi_q      <= fbi_d;
      acc_q      <= acc_d;
      sets_q     <= sets_d;
      skip_q     <= skip_d;
      total_q    <= total_d;
      npp_q      <= npp_d;
      flen_q     <= flen_d;
      sstart_q   <= sstart_d;
    end
  end

  // A summary always returns the parser to the start of a sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push_o && job_o.has_summary |=> phase_q == PhIdle && byte_pos_q == 32'd0)
    else $error("summary did not close the sample");

endmodule

// ===== hw/rtl/avcnib_queue.sv =====
// ----------------------------------------------------------------------------
// AVC NAL index builder job queue
// Small register FIFO that decouples the parser from the result emitter.
// ----------------------------------------------------------------------------
module avcnib_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  avcnib_pkg::job_t push_job_i,
  output logic             full_o,
  input  logic             pop_i,
  output avcnib_pkg::job_t head_job_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  avcnib_pkg::job_t        slots_q [DEPTH];
  logic [PtrW-1:0]         wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]         count_q;

  assign full_o     = (count_q == CntW'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign head_job_o = slots_q[rd_ptr_q];

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_job_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("job queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("job queue underflow");

endmodule

// ===== hw/rtl/avcnib_back.sv =====
// ----------------------------------------------------------------------------
// AVC NAL index builder result emitter
// Holds one job and hands out its entry and summary as separate beats.
// ----------------------------------------------------------------------------
module avcnib_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  avcnib_pkg::job_t head_job_i,
  input  logic             queue_empty_i,
  output logic             queue_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic             kind_o,
  output logic [31:0]      nal_offset_o,
  output logic [31:0]      nal_size_o,
  output logic [31:0]      nal_count_o,
  output logic [31:0]      new_frame_len_o,
  output logic             last_o
);

  avcnib_pkg::job_t cur_q;
  logic             cur_vld_q, cur_vld_d;
  logic             ent_done_q, ent_done_d;
  logic             show_entry;
  logic             take;
  logic             finish;
  logic [31:0]      aligned_len;

  assign show_entry = cur_q.has_entry && !ent_done_q;
  assign take       = cur_vld_q && pop_i;
  assign finish     = take && !(show_entry && cur_q.has_summary);

  // Load the next job when the holding register is free or just drained.
  assign queue_pop_o = !queue_empty_i && (!cur_vld_q || finish);

  always_comb begin
    cur_vld_d  = cur_vld_q;
    ent_done_d = ent_done_q;
    if (queue_pop_o) begin
      cur_vld_d  = 1'b1;
      ent_done_d = 1'b0;
    end else if (finish) begin
      cur_vld_d  = 1'b0;
      ent_done_d = 1'b0;
    end else if (take) begin
      ent_done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q  <= 1'b0;
      ent_done_q <= 1'b0;
    end else begin
      cur_vld_q  <= cur_vld_d;
      ent_done_q <= ent_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (queue_pop_o) begin
      cur_q <= head_job_i;
    end
  end

  // Summary length: frame length rounded up to four, eight per entry, plus four.
  assign aligned_len = (cur_q.sum_frame_len + 32'd3) & ~32'd3;

  assign empty_o         = !cur_vld_q;
  assign kind_o          = show_entry ? avcnib_pkg::KindEntry : avcnib_pkg::KindSummary;
  assign nal_offset_o    = show_entry ? cur_q.entry_offset : 32'd0;
  assign nal_size_o      = show_entry ? cur_q.entry_size : 32'd0;
  assign nal_count_o     = show_entry ? 32'd0 : cur_q.sum_count;
  assign new_frame_len_o = show_entry ? 32'd0
                         : aligned_len + {cur_q.sum_count[28:0], 3'b000} + 32'd4;
  assign last_o          = show_entry ? !cur_q.has_summary : 1'b1;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_vld_q && !pop_i |=> cur_vld_q)
    else $error("held result dropped without a pop");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_vld_q && kind_o == avcnib_pkg::KindSummary |-> last_o)
    else $error("summary beat not marked last");

endmodule

// ===== tb/sv/tb_avc_nal_index_builder_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AVC NAL index builder testbench
// Streams AVC samples into the index builder one byte per beat and checks each
// index entry and end-of-sample summary against a byte-level model of the
// parser. Samples are mostly well-formed (configuration record and
// length-prefixed NAL units with random content), with some noise, cut-off
// samples, odd slice starts and oversized length fields.
// ----------------------------------------------------------------------------
module tb_avc_nal_index_builder_top;

  localparam int unsigned CLK_HALF       = 2;
  localparam int unsigned RESET_CYCLES   = 10;
  localparam int unsigned ITEM_TARGET    = 1750;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 10;

  // Parser phases, in the order that a first frame walks them.
  typedef enum logic [2:0] {
    PhIdle, PhHeader, PhSps, PhPpsCount, PhPps, PhRecDone, PhSlice, PhTail
  } parse_phase_e;

  typedef struct {
    logic        kind;
    logic [31:0] nal_offset;
    logic [31:0] nal_size;
    logic [31:0] nal_count;
    logic [31:0] new_frame_len;
    logic        last;
  } nal_result_t;

  // Tracks the parser state byte by byte and holds the index entries and
  // summaries still owed by the block.
  class nal_index_scoreboard;
    nal_result_t  expected_q[$];
    int unsigned  mismatches;
    parse_phase_e phase;
    logic [31:0]  pos;
    logic [31:0]  accum;
    logic [31:0]  skip_left;
    logic [31:0]  entries;
    logic [31:0]  prefix_pos;
    logic [31:0]  frame_len_q;
    logic [31:0]  slice_start_q;
    logic [7:0]   sets_left;
    logic [1:0]   field_idx;
    logic         first_q;

    function new();
      mismatches    = 0;
      phase         = PhIdle;
      pos           = '0;
      accum         = '0;
      skip_left     = '0;
      entries       = '0;
      prefix_pos    = '0;
      frame_len_q   = '0;
      slice_start_q = '0;
      sets_left     = '0;
      field_idx     = '0;
      first_q       = 1'b0;
    endfunction

    function int unsigned waiting();
      return expected_q.size();
    endfunction

    function void add_entry(ref nal_result_t step_q[$], input logic [31:0] off,
                            input logic [31:0] len);
      nal_result_t r;
      r.kind          = avcnib_pkg::KindEntry;
      r.nal_offset    = off;
      r.nal_size      = len;
      r.nal_count     = '0;
      r.new_frame_len = '0;
      r.last          = 1'b0;
      step_q.push_back(r);
      entries = entries + 32'd1;
    endfunction

    // Note one accepted byte and queue the results that it causes.
    function void add_byte(logic [7:0] b, logic [31:0] fl, logic [31:0] dis, logic ff);
      nal_result_t step_q[$];
      nal_result_t r;
      logic [63:0] pos_next;
      logic [63:0] nxt;
      logic [63:0] aligned;
      logic [31:0] len;

      // The first byte of a sample latches its length and slice start.
      if (phase == PhIdle) begin
        frame_len_q   = (fl == 32'd0) ? 32'd1 : fl;
        first_q       = ff;
        slice_start_q = ff ? dis : 32'd0;
        pos           = '0;
        entries       = '0;
        field_idx     = '0;
        accum         = '0;
        sets_left     = '0;
        skip_left     = '0;
        prefix_pos    = slice_start_q;
        phase         = (first_q && slice_start_q != 32'd0) ? PhHeader : PhSlice;
      end else if (phase >= PhHeader && phase <= PhRecDone && pos == slice_start_q) begin
        // The record walk stops at the slice start.
        phase      = PhSlice;
        prefix_pos = pos;
        field_idx  = '0;
        accum      = '0;
      end
      pos_next = {32'd0, pos} + 64'd1;

      case (phase)
        PhHeader: begin
          if (pos == 32'd5) begin
            sets_left = {3'd0, b[4:0]};
            field_idx = '0;
            skip_left = '0;
            phase     = (sets_left != 8'd0) ? PhSps : PhPpsCount;
          end
        end
        PhSps, PhPps: begin
          if (skip_left != 32'd0) begin
            skip_left = skip_left - 32'd1;
          end else if (field_idx == 2'd0) begin
            accum     = {24'd0, b};
            field_idx = 2'd1;
          end else begin
            len = {16'd0, accum[7:0], b};
            add_entry(step_q, pos_next[31:0], len);
            skip_left = len;
            sets_left = sets_left - 8'd1;
            field_idx = '0;
          end
          if (skip_left == 32'd0 && field_idx == 2'd0 && sets_left == 8'd0) begin
            phase = (phase == PhSps) ? PhPpsCount : PhRecDone;
          end
        end
        PhPpsCount: begin
          sets_left = b;
          field_idx = '0;
          skip_left = '0;
          phase     = (b != 8'd0) ? PhPps : PhRecDone;
        end
        PhSlice: begin
          if (field_idx != 2'd0 || pos == prefix_pos) begin
            accum = (field_idx == 2'd0) ? {24'd0, b} : {accum[23:0], b};
            if (field_idx == 2'd3) begin
              nxt = pos_next + {32'd0, accum};
              // A prefix whose payload would start past the sample gives no entry.
              if (pos_next < {32'd0, frame_len_q}) begin
                add_entry(step_q, pos_next[31:0], accum);
              end
              field_idx = '0;
              if (nxt > 64'h0000_0000_FFFF_FFFF) begin
                phase = PhTail;
              end else begin
                prefix_pos = nxt[31:0];
              end
            end else begin
              field_idx = field_idx + 2'd1;
            end
          end
        end
        default: ;
      endcase

      // The last byte of the sample closes it with a summary.
      if (pos_next >= {32'd0, frame_len_q}) begin
        aligned         = (({32'd0, frame_len_q} + 64'd3) >> 2) << 2;
        r.kind          = avcnib_pkg::KindSummary;
        r.nal_offset    = '0;
        r.nal_size      = '0;
        r.nal_count     = entries;
        r.new_frame_len = 32'(aligned + ({32'd0, entries} << 3) + 64'd4);
        r.last          = 1'b0;
        step_q.push_back(r);
        phase = PhIdle;
        pos   = '0;
      end else begin
        pos = pos_next[31:0];
      end

      if (step_q.size() != 0) begin
        step_q[step_q.size() - 1].last = 1'b1;
      end
      foreach (step_q[i]) expected_q.push_back(step_q[i]);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    // Compare one accepted result beat with the oldest expectation.
    function void check_result(logic kind, logic [31:0] off, logic [31:0] len,
                               logic [31:0] cnt, logic [31:0] new_len, logic last);
      nal_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected: kind %0d offset 0x%0h", kind, off);
        mismatches++;
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("kind", 32'(exp_r.kind), 32'(kind));
      compare_field("nal_offset", exp_r.nal_offset, off);
      compare_field("nal_size", exp_r.nal_size, len);
      compare_field("nal_count", exp_r.nal_count, cnt);
      compare_field("new_frame_len", exp_r.new_frame_len, new_len);
      compare_field("last", 32'(exp_r.last), 32'(last));
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  data_byte;
  logic [31:0] frame_len;
  logic [31:0] dec_info_size;
  logic        first_frame;
  logic        empty;
  logic        pop = 1'b0;
  logic        kind;
  logic [31:0] nal_offset;
  logic [31:0] nal_size;
  logic [31:0] nal_count;
  logic [31:0] new_frame_len;
  logic        last;

  nal_index_scoreboard sb;
  logic [7:0]  frame_bytes[$];
  int unsigned bytes_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  int unsigned pop_calm = 0;
  bit          quiet_tail = 1'b0;
  bit          sender_calm = 1'b0;

  avc_nal_index_builder_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .data_byte_i     (data_byte),
    .frame_len_i     (frame_len),
    .dec_info_size_i (dec_info_size),
    .first_frame_i   (first_frame),
    .empty           (empty),
    .pop             (pop),
    .kind_o          (kind),
    .nal_offset_o    (nal_offset),
    .nal_size_o      (nal_size),
    .nal_count_o     (nal_count),
    .new_frame_len_o (new_frame_len),
    .last_o          (last)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Result side: stalls come in bursts, with calm stretches and none at the end.
  always @(posedge clk_i) begin
    if (pop_calm != 0) begin
      pop_calm--;
      pop <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      pop <= 1'b0;
    end else if (quiet_tail) begin
      pop <= 1'b1;
    end else begin
      case ($urandom_range(0, 15))
        0, 1: begin
          stall_left = $urandom_range(0, 5);
          pop <= 1'b0;
        end
        2: begin
          pop_calm = $urandom_range(20, 80);
          pop <= 1'b1;
        end
        default: pop <= 1'b1;
      endcase
    end
  end

  // Both handshakes are sampled at the edge, before any drive of this step lands.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        sb.add_byte(data_byte, frame_len, dec_info_size, first_frame);
      end
      if (pop && !empty) begin
        sb.check_result(kind, nal_offset, nal_size, nal_count, new_frame_len, last);
      end
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
  end

  // Watchdog: too long without any beat on either side.
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("avc_nal_index_builder_top verification failed");
    $finish;
  end

  // Offer one byte, after an optional idle burst, and wait for its beat.
  task automatic send_byte(input logic [7:0] b, input logic [31:0] fl,
                           input logic [31:0] dis, input logic ff);
    if (!quiet_tail && !sender_calm && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    push          <= 1'b1;
    data_byte     <= b;
    frame_len     <= fl;
    dec_info_size <= dis;
    first_frame   <= ff;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Send the bytes in frame_bytes; only the first carries the sample fields,
  // the others carry random values that the block ignores.
  task automatic send_frame(input logic [31:0] fl, input logic [31:0] dis, input logic ff);
    foreach (frame_bytes[i]) begin
      if (i == 0) begin
        send_byte(frame_bytes[i], fl, dis, ff);
      end else begin
        send_byte(frame_bytes[i], $urandom, $urandom, 1'($urandom));
      end
    end
  endtask

  // Hold the sender until every expected result has been taken.
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.waiting() != 0) @(posedge clk_i);
  endtask

  // Append parameter sets: a 2-byte size and the payload each. An oversized
  // set is cut short and ends the sample content.
  task automatic add_param_sets(input int unsigned count, inout bit cut);
    int unsigned len;
    for (int i = 0; i < count && !cut; i++) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 8);
      frame_bytes.push_back(8'(len >> 8));
      frame_bytes.push_back(8'(len));
      if (len > 16) begin
        repeat ($urandom_range(0, 8)) frame_bytes.push_back(8'($urandom));
        cut = 1'b1;
      end else begin
        repeat (len) frame_bytes.push_back(8'($urandom));
      end
    end
  endtask

  task automatic build_random_frame(output logic [31:0] fl, output logic [31:0] dis,
                                    output logic ff);
    int unsigned mode;
    int unsigned count;
    int unsigned len;
    int unsigned rec_len;
    logic [31:0] nal_len;
    bit          cut;

    frame_bytes.delete();
    mode = $urandom_range(0, 9);
    cut  = 1'b0;
    ff   = (mode >= 1 && mode <= 4);
    dis  = '0;
    if (mode == 0) begin
      // Noise: short samples of random bytes.
      repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom));
      ff  = 1'($urandom);
      dis = $urandom_range(0, 15);
    end else begin
      // Configuration record of a first frame.
      if (ff) begin
        repeat (5) frame_bytes.push_back(8'($urandom));
        count = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 31) : $urandom_range(0, 3);
        frame_bytes.push_back({3'($urandom), 5'(count)});
        add_param_sets(count, cut);
        if (!cut) begin
          count = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 40) : $urandom_range(0, 3);
          frame_bytes.push_back(8'(count));
          add_param_sets(count, cut);
        end
        rec_len = frame_bytes.size();
        case ($urandom_range(0, 15))
          0:       dis = $urandom;
          1, 2:    dis = rec_len - $urandom_range(1, 3);
          3:       dis = rec_len + $urandom_range(1, 3);
          default: dis = rec_len;
        endcase
        if (dis > rec_len && dis <= rec_len + 3) begin
          while (frame_bytes.size() < dis) frame_bytes.push_back(8'($urandom));
        end
      end
      // Length-prefixed NAL units.
      count = $urandom_range(0, 4);
      for (int i = 0; i < count && !cut; i++) begin
        nal_len = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 10);
        frame_bytes.push_back(nal_len[31:24]);
        frame_bytes.push_back(nal_len[23:16]);
        frame_bytes.push_back(nal_len[15:8]);
        frame_bytes.push_back(nal_len[7:0]);
        if (nal_len > 16) begin
          repeat ($urandom_range(0, 8)) frame_bytes.push_back(8'($urandom));
          cut = 1'b1;
        end else begin
          repeat (nal_len) frame_bytes.push_back(8'($urandom));
        end
      end
    end

    // Usually the sample length matches the content; sometimes it cuts it
    // short or pads it.
    len = frame_bytes.size();
    case ($urandom_range(0, 5))
      0: if (len > 1) len = len - $urandom_range(1, (len > 4) ? 4 : len - 1);
      1: len = len + $urandom_range(1, 4);
      default: ;
    endcase
    if (len == 0) len = 1;
    while (frame_bytes.size() > len) void'(frame_bytes.pop_back());
    while (frame_bytes.size() < len) frame_bytes.push_back(8'($urandom));
    fl = len;
    if (len == 1 && $urandom_range(0, 1) == 0) fl = '0;
  endtask

  initial begin
    logic [31:0] fl;
    logic [31:0] dis;
    logic        ff;
    bit          drained_mid;

    sb            = new();
    drained_mid   = 1'b0;
    rst_ni        = 1'b0;
    push          = 1'b0;
    data_byte     = '0;
    frame_len     = '0;
    dec_info_size = '0;
    first_frame   = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero frame length: a one-byte sample.
    frame_bytes = '{8'h00};
    send_frame(32'd0, 32'hFFFF_FFFF, 1'b0);
    // First frame with zero slice start: no record walk.
    frame_bytes = '{8'hFF};
    send_frame(32'd1, 32'd0, 1'b1);
    // Largest length prefix: the next prefix would lie beyond the position range.
    frame_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hAA};
    send_frame(32'd6, 32'd0, 1'b0);
    // Prefix that ends the sample gives no entry.
    frame_bytes = '{8'h00, 8'h00, 8'h00, 8'h01};
    send_frame(32'd4, 32'd0, 1'b0);
    // Slice start inside the SPS payload: the rest is read as slice data.
    frame_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hE1, 8'h00, 8'h02,
                    8'h5A, 8'h00, 8'h00, 8'h00, 8'h00, 8'hC3};
    send_frame(32'd14, 32'd9, 1'b1);
    // No SPS, one PPS whose size ends on the last byte: entry and summary together.
    frame_bytes = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'hE0, 8'h01, 8'h00, 8'h01};
    send_frame(32'd9, 32'hFFFF_FFFF, 1'b1);
    drain_results();

    // Random samples; the sender drains once half-way and idles no more near the end.
    while (bytes_sent < ITEM_TARGET) begin
      if (!drained_mid && bytes_sent >= ITEM_TARGET / 2) begin
        drain_results();
        drained_mid = 1'b1;
      end
      quiet_tail  = (bytes_sent >= ITEM_TARGET * 85 / 100);
      sender_calm = ($urandom_range(0, 3) == 0);
      build_random_frame(fl, dis, ff);
      send_frame(fl, dis, ff);
    end

    // Largest sample length and slice start: the sample stays open to the end.
    frame_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00,
                    8'h00, 8'h7F, 8'h80, 8'hFF};
    send_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("avc_nal_index_builder_top verification clean");
    end else begin
      $display("avc_nal_index_builder_top verification failed");
    end
    $finish;
  end

endmodule
